// ===== design/radix64_stream_codec_unit_defines.svh =====
// Assertion macros shared by the radix-64 codec RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef RADIX64_STREAM_CODEC_UNIT_DEFINES_SVH
`define RADIX64_STREAM_CODEC_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define R64_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define R64_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/r64_pkg.sv =====
// Types, constants and symbol lookup functions for the radix-64 codec.
// Has no dependencies; used by r64_step and radix64_stream_codec_unit.
package r64_pkg;

    // Symbol alphabet in four rows of sixteen; the first character is symbol value 0.
    localparam logic [8*64-1:0] ALPHABET_STR = {
        "PaAwO65goUf7IK2v",
        "i9-xq8cFTEXLCDY1",
        "Hd3tV0ryzjbpN_Bl",
        "nSs4mGRkQWMZJeuh"
    };

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // One result word.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       no_data;
        logic       bad;
    } res_t;

    // Codec state carried between input words.
    typedef struct packed {
        logic [1:0] phase;
        logic [5:0] carry;
        logic       bad_pending;
    } st_t;

    // Everything one input word produces.
    typedef struct packed {
        res_t       res0;
        res_t       res1;
        logic [1:0] count;
        st_t        next_state;
    } step_t;

    // Symbol character for a 6-bit value.
    function automatic logic [7:0] enc_symbol(input logic [5:0] v);
        logic [7:0] ch;
        ch = '0;
        for (int i = 0; i < 64; i++) begin
            if (v == i[5:0]) begin
                ch = ALPHABET_STR[8*(63-i) +: 8];
            end
        end
        return ch;
    endfunction

    // Value of a symbol character; the top bit flags a character outside
    // the alphabet, in which case the value is zero.
    function automatic logic [6:0] dec_symbol(input logic [7:0] code);
        logic [6:0] res;
        res = 7'b1_000000;
        for (int i = 0; i < 64; i++) begin
            if (code == ALPHABET_STR[8*(63-i) +: 8]) begin
                res = {1'b0, i[5:0]};
            end
        end
        return res;
    endfunction

endpackage

// ===== design/r64_step.sv =====
// Combinational step of the radix-64 codec: results and next state for one word.
// Depends on r64_pkg.
module r64_step (
    input  logic           direction,
    input  r64_pkg::st_t   state,
    input  logic [7:0]     data_in,
    input  logic           last_item,
    output r64_pkg::step_t step
);
    import r64_pkg::*;

    logic [6:0] lookup;
    logic [5:0] d;
    logic       bad;
    logic [7:0] byte_val;

    assign lookup = dec_symbol(data_in);
    assign d      = lookup[5:0];
    assign bad    = lookup[6];

    // Decoded byte for the current phase.
    always_comb
    begin
        case (state.phase)
            2'd1:    byte_val = {d[1:0], state.carry[5:0]};
            2'd2:    byte_val = {d[3:0], state.carry[3:0]};
            2'd3:    byte_val = {d[5:0], state.carry[1:0]};
            default: byte_val = '0;
        endcase
    end

    // Results and next state.
    always_comb
    begin
        step            = '0;
        step.next_state = state;
        if (direction == DIR_ENCODE) begin
            case (state.phase)
                2'd1:
                begin
                    step.res0.data             = enc_symbol({data_in[3:0], state.carry[1:0]});
                    step.next_state.carry      = {2'b00, data_in[7:4]};
                    step.next_state.phase      = 2'd2;
                    step.count                 = 2'd1;
                    if (last_item) begin
                        step.res1.data  = enc_symbol({2'b00, data_in[7:4]});
                        step.res1.last  = 1'b1;
                        step.count      = 2'd2;
                        step.next_state = '0;
                    end
                end
                2'd2:
                begin
                    step.res0.data  = enc_symbol({data_in[1:0], state.carry[3:0]});
                    step.res1.data  = enc_symbol(data_in[7:2]);
                    step.res1.last  = last_item;
                    step.count      = 2'd2;
                    step.next_state = '0;
                end
                default:
                begin
                    // Phase three cannot occur while encoding; it acts as phase zero.
                    step.res0.data             = enc_symbol(data_in[5:0]);
                    step.next_state.carry      = {4'b0000, data_in[7:6]};
                    step.next_state.phase      = 2'd1;
                    step.next_state.bad_pending = 1'b0;
                    step.count                 = 2'd1;
                    if (last_item) begin
                        step.res1.data  = enc_symbol({4'b0000, data_in[7:6]});
                        step.res1.last  = 1'b1;
                        step.count      = 2'd2;
                        step.next_state = '0;
                    end
                end
            endcase
        end else begin
            case (state.phase)
                2'd0:
                begin
                    if (last_item) begin
                        // A lone trailing symbol is dropped and marked empty.
                        step.res0.last    = 1'b1;
                        step.res0.no_data = 1'b1;
                        step.res0.bad     = bad;
                        step.count        = 2'd1;
                        step.next_state   = '0;
                    end else begin
                        step.next_state.carry       = d;
                        step.next_state.bad_pending = bad;
                        step.next_state.phase       = 2'd1;
                    end
                end
                default:
                begin
                    step.res0.data = byte_val;
                    step.res0.last = last_item;
                    step.res0.bad  = state.bad_pending | bad;
                    step.count     = 2'd1;
                    step.next_state.bad_pending = bad;
                    case (state.phase)
                        2'd1:
                        begin
                            step.next_state.carry = {2'b00, d[5:2]};
                            step.next_state.phase = 2'd2;
                        end
                        2'd2:
                        begin
                            step.next_state.carry = {4'b0000, d[5:4]};
                            step.next_state.phase = 2'd3;
                        end
                        default:
                        begin
                            step.next_state = '0;
                        end
                    endcase
                    if (last_item) begin
                        step.next_state = '0;
                    end
                end
            endcase
        end
    end

endmodule

// ===== design/radix64_stream_codec_unit.sv =====
// Top level of the radix-64 stream codec: input stage, state and result buffer.
// Depends on r64_pkg, r64_step and radix64_stream_codec_unit_defines.svh.
//
// Usage: configure direction through the cfg channel (cfg_valid, cfg_ready,
// cfg_data) while the block is idle; 0 encodes bytes to symbols, 1 decodes
// symbols to bytes. Each write also restarts the current group. cfg_ready is
// high only when no word is held anywhere in the block.
// Input words (data_in, last_item) enter on in_valid/in_ready; result words
// (data_out, last_result, no_data, bad_symbol) leave on out_valid/out_ready.
// The input register feeds the codec logic, which writes up to two results into
// a two-word result buffer. Throughput: one input word per cycle while each word
// gives at most one result (decoding) and the receiver takes every result; a word
// that gives two results (encoding) slows the input, since the single result port
// drains the buffer one word at a time.
// Reset sets direction to encode, clears the group state and empties both buffers.
// When the receiver stalls, the buffer holds its words and the input stage
// fills and then drops in_ready; nothing is lost or repeated.
module radix64_stream_codec_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_in,
    input  logic       last_item,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] data_out,
    output logic       last_result,
    output logic       no_data,
    output logic       bad_symbol
);
    import r64_pkg::*;

`include "radix64_stream_codec_unit_defines.svh"

    logic       direction_reg;
    st_t        state_reg;
    logic       stage_valid_reg;
    logic [7:0] stage_data_reg;
    logic       stage_last_reg;
    res_t       buf0_reg;
    res_t       buf1_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    step_t      step;
    logic       pop;
    logic       can_load;
    logic       advance;
    logic       in_acc;
    logic       cfg_acc;

    r64_step u_step (
        .direction (direction_reg),
        .state     (state_reg),
        .data_in   (stage_data_reg),
        .last_item (stage_last_reg),
        .step      (step)
    );

    // Handshake control.
    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign can_load  = (count_reg == 2'd0) || ((count_reg == 2'd1) && pop);
    assign advance   = stage_valid_reg && ((step.count == 2'd0) || can_load);
    assign in_ready  = !stage_valid_reg || advance;
    assign in_acc    = in_valid && in_ready;
    assign cfg_ready = !stage_valid_reg && (count_reg == 2'd0);
    assign cfg_acc   = cfg_valid && cfg_ready;

    assign data_out    = buf0_reg.data;
    assign last_result = buf0_reg.last;
    assign no_data     = buf0_reg.no_data;
    assign bad_symbol  = buf0_reg.bad;

    // Buffer fill level.
    always_comb
    begin
        count_next = count_reg;
        if (advance && (step.count != 2'd0)) begin
            count_next = step.count;
        end else if (pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            direction_reg   <= DIR_ENCODE;
            state_reg       <= '0;
            stage_valid_reg <= 1'b0;
            count_reg       <= 2'd0;
        end else begin
            if (cfg_acc) begin
                direction_reg <= cfg_data;
                state_reg     <= '0;
            end else if (advance) begin
                state_reg <= step.next_state;
            end
            if (in_acc) begin
                stage_valid_reg <= 1'b1;
            end else if (advance) begin
                stage_valid_reg <= 1'b0;
            end
            count_reg <= count_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_acc) begin
            stage_data_reg <= data_in;
            stage_last_reg <= last_item;
        end
        if (advance && (step.count != 2'd0)) begin
            buf0_reg <= step.res0;
            buf1_reg <= step.res1;
        end else if (pop) begin
            buf0_reg <= buf1_reg;
        end
    end

    // Checks on the buffer, stage, configuration and flag behaviour.
    `R64_ASSERT_IMP(a_count_range, 1'b1, count_reg != 2'd3, "result buffer overfilled")
    `R64_ASSERT_NXT(a_pair_loaded, advance && (step.count == 2'd2), count_reg == 2'd2,
        "two results not both buffered")
    `R64_ASSERT_NXT(a_stage_hold, stage_valid_reg && !advance,
        stage_valid_reg && $stable(stage_data_reg), "stalled stage word changed")
    `R64_ASSERT_NXT(a_cfg_clears, cfg_acc, state_reg == '0, "config write left group state")
    `R64_ASSERT_IMP(a_enc_flags, out_valid && (direction_reg == DIR_ENCODE),
        !bad_symbol && !no_data, "decode flags raised while encoding")

endmodule

// ===== tb/sv/radix64_stream_codec_unit_tb.sv =====
// Self-checking testbench for radix64_stream_codec_unit: directed and random words in both
// directions, checked against an internal prediction of the radix-64 codec.
// Depends on r64_pkg and the radix64_stream_codec_unit RTL.
module radix64_stream_codec_unit_tb;

    import r64_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int HOLDOFF_CYCLES = 300;

    // Symbol table: entry i is the character for 6-bit value i.
    localparam logic [0:63][7:0] SYM_ROM = {
        "PaAwO65goUf7IK2v",
        "i9-xq8cFTEXLCDY1",
        "Hd3tV0ryzjbpN_Bl",
        "nSs4mGRkQWMZJeuh"
    };

    typedef enum logic [1:0] {
        GRP_FIRST,
        GRP_SECOND,
        GRP_THIRD,
        GRP_FOURTH
    } grp_pos_e;

    logic       clk;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_data;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] data_in;
    logic       last_item;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] data_out;
    logic       last_result;
    logic       no_data;
    logic       bad_symbol;

    // Predicted codec state.
    logic       cur_dir;
    grp_pos_e   grp_pos;
    logic [5:0] leftover;
    logic       leftover_bad;

    res_t       expected_words[$];
    int         mismatches = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         holdoff_req = 0;
    int         holdoff_ack = 0;
    int         holdoff_left = 0;
    int         quiet_cycles = 0;

    radix64_stream_codec_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_in     (data_in),
        .last_item   (last_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .data_out    (data_out),
        .last_result (last_result),
        .no_data     (no_data),
        .bad_symbol  (bad_symbol)
    );

    always #5 clk = ~clk;

    // Value of a symbol character; flags characters outside the table.
    function automatic logic [5:0] symbol_value(input logic [7:0] code, output logic outside);
        outside = 1'b1;
        for (int i = 0; i < 64; i++)
        begin
            if (SYM_ROM[i] == code)
            begin
                outside = 1'b0;
                return 6'(i);
            end
        end
        return 6'd0;
    endfunction

    function automatic logic [7:0] pick_symbol();
        if ($urandom_range(9) == 0)
            return 8'($urandom);
        return SYM_ROM[$urandom_range(63)];
    endfunction

    task automatic push_word(input logic [7:0] d, input logic l, input logic nd, input logic b);
        res_t w;
        w.data    = d;
        w.last    = l;
        w.no_data = nd;
        w.bad     = b;
        expected_words.push_back(w);
    endtask

    task automatic clear_group();
        grp_pos      = GRP_FIRST;
        leftover     = '0;
        leftover_bad = 1'b0;
    endtask

    // Works out the result words that one accepted input word produces.
    task automatic predict_codec_words(input logic [7:0] din, input logic fin);
        logic [11:0] acc;
        logic [5:0]  val;
        logic        outside;
        if (cur_dir == DIR_ENCODE)
        begin
            case (grp_pos)
                GRP_SECOND:
                begin
                    acc = {6'd0, leftover} | ({4'd0, din} << 2);
                    push_word(SYM_ROM[acc[5:0]], 1'b0, 1'b0, 1'b0);
                    leftover = acc[11:6];
                    grp_pos  = GRP_THIRD;
                    if (fin)
                    begin
                        push_word(SYM_ROM[leftover], 1'b1, 1'b0, 1'b0);
                        clear_group();
                    end
                end
                GRP_THIRD:
                begin
                    acc = {6'd0, leftover} | ({4'd0, din} << 4);
                    push_word(SYM_ROM[acc[5:0]], 1'b0, 1'b0, 1'b0);
                    push_word(SYM_ROM[acc[11:6]], fin, 1'b0, 1'b0);
                    clear_group();
                end
                default:
                begin
                    // The fourth position cannot occur while encoding; it acts as the first.
                    push_word(SYM_ROM[din[5:0]], 1'b0, 1'b0, 1'b0);
                    leftover = {4'd0, din[7:6]};
                    grp_pos  = GRP_SECOND;
                    if (fin)
                    begin
                        push_word(SYM_ROM[leftover], 1'b1, 1'b0, 1'b0);
                        clear_group();
                    end
                end
            endcase
        end
        else
        begin
            val = symbol_value(din, outside);
            case (grp_pos)
                GRP_FIRST:
                begin
                    // A lone final symbol yields an empty word.
                    if (fin)
                        push_word(8'd0, 1'b1, 1'b1, outside);
                    else
                    begin
                        leftover     = val;
                        leftover_bad = outside;
                        grp_pos      = GRP_SECOND;
                    end
                end
                GRP_SECOND:
                begin
                    push_word({val[1:0], leftover}, fin, 1'b0, leftover_bad | outside);
                    leftover     = {2'd0, val[5:2]};
                    leftover_bad = outside;
                    grp_pos      = GRP_THIRD;
                end
                GRP_THIRD:
                begin
                    push_word({val[3:0], leftover[3:0]}, fin, 1'b0, leftover_bad | outside);
                    leftover     = {4'd0, val[5:4]};
                    leftover_bad = outside;
                    grp_pos      = GRP_FOURTH;
                end
                default:
                begin
                    push_word({val, leftover[1:0]}, fin, 1'b0, leftover_bad | outside);
                    clear_group();
                end
            endcase
            if (fin)
                clear_group();
        end
    endtask

    // Offers one input word, after random idle cycles, and waits for it to be taken.
    task automatic send_word(input logic [7:0] d, input logic fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_in   <= d;
        last_item <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_codec_words(d, fin);
    endtask

    // Stops offering words and waits until every predicted word has come out.
    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_direction(input logic dir);
        wait_all_results();
        cfg_valid <= 1'b1;
        cfg_data  <= dir;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cur_dir = dir;
        clear_group();
    endtask

    task automatic test_encode_directed();
        write_direction(DIR_ENCODE);
        // One-byte tail, two-byte tail, full group, group followed by a tail.
        send_word(8'hFF, 1'b1);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b1);
        send_word(8'hA5, 1'b0);
        send_word(8'h5A, 1'b0);
        send_word(8'h80, 1'b1);
        send_word(8'h01, 1'b0);
        send_word(8'h7F, 1'b0);
        send_word(8'hFE, 1'b0);
        send_word(8'h00, 1'b1);
        wait_all_results();
    endtask

    task automatic test_decode_directed();
        write_direction(DIR_DECODE);
        // Full group of the highest value.
        send_word("h", 1'b0);
        send_word("h", 1'b0);
        send_word("h", 1'b0);
        send_word("h", 1'b1);
        // Lone final symbol, inside and outside the table.
        send_word("P", 1'b1);
        send_word(8'hFF, 1'b1);
        send_word(8'h00, 1'b1);
        // Symbol outside the table in the middle of a group.
        send_word("a", 1'b0);
        send_word(8'h80, 1'b0);
        send_word("P", 1'b1);
        // Tail symbol with bits beyond the last whole byte.
        send_word("h", 1'b0);
        send_word("h", 1'b1);
        // Whole group, then a lone symbol closing the message.
        send_word(8'h00, 1'b0);
        send_word("P", 1'b0);
        send_word("h", 1'b0);
        send_word("w", 1'b0);
        send_word("P", 1'b1);
        wait_all_results();
    endtask

    // A direction write in the middle of a group restarts the group.
    task automatic test_direction_writes();
        write_direction(DIR_ENCODE);
        send_word(8'h3C, 1'b0);
        write_direction(DIR_ENCODE);
        send_word(8'hC3, 1'b1);
        write_direction(DIR_DECODE);
        send_word("O", 1'b0);
        write_direction(DIR_DECODE);
        send_word("g", 1'b0);
        send_word("o", 1'b1);
        write_direction(DIR_DECODE);
        send_word("6", 1'b0);
        send_word("5", 1'b0);
        write_direction(DIR_ENCODE);
        send_word(8'h96, 1'b1);
        wait_all_results();
    endtask

    // The receiver holds off while the sender keeps offering, so the block fills up.
    task automatic test_receiver_holdoff();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_direction(DIR_ENCODE);
        holdoff_req++;
        for (int i = 0; i < 30; i++)
            send_word(8'($urandom), i == 29);
        wait_all_results();
        write_direction(DIR_DECODE);
        holdoff_req++;
        for (int i = 0; i < 30; i++)
            send_word(pick_symbol(), i == 29);
        wait_all_results();
    endtask

    task automatic test_random_traffic(input int n_words, input int s_idle, input int r_idle);
        int         sent;
        int         msg_len;
        logic [7:0] d;
        logic       fin;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        sent = 0;
        while (sent < n_words)
        begin
            if ($urandom_range(7) == 0)
                write_direction(1'($urandom_range(1)));
            else if ($urandom_range(19) == 0)
                wait_all_results();
            msg_len = ($urandom_range(3) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 6);
            for (int i = 0; i < msg_len; i++)
            begin
                d = (cur_dir == DIR_DECODE) ? pick_symbol() : 8'($urandom);
                // Mostly well-formed messages; now and then a stray or missing end mark.
                if (i == msg_len - 1)
                    fin = ($urandom_range(9) != 0);
                else
                    fin = ($urandom_range(29) == 0);
                send_word(d, fin);
            end
            sent += msg_len;
        end
        wait_all_results();
    endtask

    // Receiver: random stalls, plus a long hold-off on request.
    always @(posedge clk)
    begin
        if (holdoff_left != 0)
        begin
            out_ready    <= 1'b0;
            holdoff_left <= holdoff_left - 1;
        end
        else if (holdoff_req != holdoff_ack)
        begin
            out_ready    <= 1'b0;
            holdoff_ack  <= holdoff_req;
            holdoff_left <= HOLDOFF_CYCLES;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compares each result word with the oldest prediction.
    always @(posedge clk)
    begin : result_check
        res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected result word: data_out %0h last_result %0b", data_out,
                       last_result);
                mismatches++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (data_out !== want.data)
                begin
                    $error("data_out: expected %0h, got %0h", want.data, data_out);
                    mismatches++;
                end
                if (last_result !== want.last)
                begin
                    $error("last_result: expected %0b, got %0b", want.last, last_result);
                    mismatches++;
                end
                if (no_data !== want.no_data)
                begin
                    $error("no_data: expected %0b, got %0b", want.no_data, no_data);
                    mismatches++;
                end
                if (bad_symbol !== want.bad)
                begin
                    $error("bad_symbol: expected %0b, got %0b", want.bad, bad_symbol);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: ends the run when no word moves on any channel for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        in_valid  = 1'b0;
        data_in   = 8'd0;
        last_item = 1'b0;
        out_ready = 1'b0;
        cur_dir   = DIR_ENCODE;
        clear_group();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_encode_directed();
        test_decode_directed();
        test_direction_writes();
        test_receiver_holdoff();
        test_random_traffic(340, 12, 49);
        test_random_traffic(340, 49, 12);
        test_random_traffic(340, 0, 0);
        wait_all_results();

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/r64_pkg.sv
design/r64_step.sv
design/radix64_stream_codec_unit.sv
tb/sv/radix64_stream_codec_unit_tb.sv
